[sv/bca_pkg.sv]
// ----------------------------------------------------------------------------
// Block chain allocator package
// Shared types, codes and constants for the allocator controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package bca_pkg;

  // Default depth of the bitmap and the next-block table.
  localparam int NUM_BLOCKS_DEF = 1024;

  // Fixed widths of the item fields.
  localparam int COUNT_W = 11;
  localparam int BLOCK_W = 10;

  // Block count after reset.
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_NEXT  = 3'd2,
    OP_MARK  = 3'd3,
    OP_LINK  = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } res_status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC_SCAN,
    S_ALLOC_LINK,
    S_ALLOC_END,
    S_FREE_GET,
    S_FREE_SCAN,
    S_FREE_WR,
    S_NEXT_GET,
    S_RESP
  } state_t;

  // Request word.
  typedef struct packed {
    op_t                mode;
    logic [BLOCK_W-1:0] block;
    logic [BLOCK_W-1:0] link_block;
    logic               link_valid;
    logic               flag;
  } req_t;

  // Response word.
  typedef struct packed {
    res_status_t        status;
    logic [BLOCK_W-1:0] result_block;
    logic               result_end;
  } rsp_t;

  // Configuration word.
  typedef struct packed {
    logic [COUNT_W-1:0] data_block_count;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic scan_start;
    logic scan_step;
    logic wr_mark;
    logic wr_link;
    logic alloc_link;
    logic alloc_end;
    logic free_get;
    logic free_wr;
    logic next_get;
    logic res_ok;
    logic res_full;
    logic res_range;
    logic res_alloc;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  mode;
    logic flag;
    logic blk_oor;
    logic lnk_oor;
    logic scan_hit;
    logic scan_exh;
    logic clr_last;
  } sts_t;

endpackage

[sv/bca_chan_if.sv]
// ----------------------------------------------------------------------------
// Allocator channel interface
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface bca_chan_if #(parameter type T = logic) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[sv/block_chain_allocator.sv]
// ----------------------------------------------------------------------------
// Block chain allocator
// Used/free bitmap and next-block table with allocate, free with optional
// unlink, next lookup, mark and link operations.
// ----------------------------------------------------------------------------
//
//   channel  dir  word                                              handshake
//   req      in   mode, block, link_block, link_valid, flag         valid/ready
//   rsp      out  status, result_block, result_end                  valid/ready
//   cfg      in   data_block_count                                  valid/ready
//
// One request word is worked on at a time. Allocate and free with unlink scan
// the bitmap or the table over the B active blocks, where B is the active
// block count; the scan reads one entry a cycle through a single memory port.
// After reset a clearing pass sets every block free and every entry to end of
// chain; no request is taken then, cfg always is.
// A finished response waits in the output register while the next request
// is taken; a stalled response holds the controller in its response state
// until the output register frees.
//
module block_chain_allocator #(
  parameter int NUM_BLOCKS = bca_pkg::NUM_BLOCKS_DEF
) (
  input logic        clk,
  input logic        rst,
  bca_chan_if.sink   req,
  bca_chan_if.source rsp,
  bca_chan_if.sink   cfg
);
  import bca_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_valid;

  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;

  // Controller.
  bca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  bca_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req_data (req.data),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .rsp_data (rsp.data)
  );

  // No request is taken during the clearing pass.
  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !req.ready)
    else $error("request taken during clearing pass");

  // A response is loaded only into a free output register.
  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp.valid || rsp.ready))
    else $error("response overwrote a pending word");

  // At most one table write command in a cycle.
  a_one_table_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.wr_link, cmd.alloc_link, cmd.alloc_end, cmd.free_wr}))
    else $error("conflicting table writes");

  // A taken request is followed by a busy cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request taken back to back");

endmodule

[sv/bca_dpath.sv]
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the used bitmap, the next-block table, the block count, the scan
// and clear counters, the result and the output word.
// ----------------------------------------------------------------------------
module bca_dpath #(
  parameter int NUM_BLOCKS = bca_pkg::NUM_BLOCKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  bca_pkg::cmd_t cmd,
  output bca_pkg::sts_t sts,
  input  bca_pkg::req_t req_data,
  input  logic          cfg_we,
  input  bca_pkg::cfg_t cfg_data,
  output bca_pkg::rsp_t rsp_data
);
  import bca_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int BND_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (BND_W > COUNT_W) ? BND_W : COUNT_W;
  localparam int MW    = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [IDX_W:0]   END_MARK = {(IDX_W + 1){1'b1}};

  // Memories: used bit per block, and end bit plus successor per block.
  logic             free_mem [NUM_BLOCKS];
  logic [IDX_W:0]   next_mem [NUM_BLOCKS];

  logic             fm_we;
  logic [IDX_W-1:0] fm_wa;
  logic             fm_wd;
  logic             fm_rd;
  logic             nt_we;
  logic [IDX_W-1:0] nt_wa;
  logic [IDX_W:0]   nt_wd;
  logic [IDX_W-1:0] nt_ra;
  logic [IDX_W:0]   nt_rd;

  logic [COUNT_W-1:0] count;
  logic [BND_W-1:0]   bound;
  req_t               req_q;
  logic [IDX_W-1:0]   blk_idx;
  logic [IDX_W-1:0]   lnk_idx;

  logic [IDX_W-1:0]   clr_ptr;
  logic [BND_W-1:0]   ptr;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W:0]     succ;
  logic               scan_match;
  logic               scan_more;

  res_status_t        res_status;
  logic [BLOCK_W-1:0] res_block;
  logic               res_end;

  // Active bound is the smaller of the count and the table depth.
  always_comb begin
    if (CMP_W'(count) > CMP_W'(NUM_BLOCKS)) begin
      bound = BND_W'(NUM_BLOCKS);
    end else begin
      bound = BND_W'(count);
    end
  end

  assign blk_idx = IDX_W'(req_q.block);
  assign lnk_idx = IDX_W'(req_q.link_block);

  // Range checks on the latched operands.
  assign sts.mode    = req_q.mode;
  assign sts.flag    = req_q.flag;
  assign sts.blk_oor = CMP_W'(req_q.block) >= CMP_W'(bound);
  assign sts.lnk_oor = req_q.link_valid && (CMP_W'(req_q.link_block) >= CMP_W'(bound));

  // Scan compare: a free bit for allocate, an entry equal to the block for unlink.
  always_comb begin
    if (req_q.mode == OP_ALLOC) begin
      scan_match = pend && !fm_rd;
    end else begin
      scan_match = pend && !nt_rd[IDX_W] && (MW'(nt_rd[IDX_W-1:0]) == MW'(req_q.block));
    end
  end

  assign scan_more    = ptr < bound;
  assign sts.scan_hit = scan_match;
  assign sts.scan_exh = !scan_match && !scan_more;
  assign sts.clr_last = clr_ptr == LAST_IDX;

  // Count register and clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= COUNT_RESET;
      clr_ptr <= '0;
    end else begin
      if (cfg_we) begin
        count <= cfg_data.data_block_count;
      end
      if (cmd.clr_step) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
    end
  end

  // Scan unit: issue one read a cycle, check the word read in the previous cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      pend      <= 1'b0;
      hit_found <= 1'b0;
    end else if (cmd.scan_start) begin
      ptr       <= '0;
      pend      <= 1'b0;
      hit_found <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_match) begin
        hit_found <= 1'b1;
        pend      <= 1'b0;
      end else if (scan_more) begin
        pend <= 1'b1;
        ptr  <= ptr + 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  // Scan payload, latched request and successor.
  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_match) begin
      hit_idx <= pend_idx;
    end
    if (cmd.scan_step && !scan_match && scan_more) begin
      pend_idx <= ptr[IDX_W-1:0];
    end
    if (cmd.load_in) begin
      req_q <= req_data;
    end
    if (cmd.free_get) begin
      succ <= nt_rd;
    end
  end

  // Write port selection for both memories.
  always_comb begin
    fm_we = 1'b0;
    fm_wa = blk_idx;
    fm_wd = 1'b0;
    nt_we = 1'b0;
    nt_wa = blk_idx;
    nt_wd = END_MARK;
    if (cmd.clr_step) begin
      fm_we = 1'b1;
      fm_wa = clr_ptr;
      nt_we = 1'b1;
      nt_wa = clr_ptr;
    end
    if (cmd.wr_mark) begin
      fm_we = 1'b1;
      fm_wd = req_q.flag;
    end
    if (cmd.wr_link) begin
      nt_we = 1'b1;
      nt_wd = req_q.link_valid ? {1'b0, lnk_idx} : END_MARK;
    end
    if (cmd.alloc_link) begin
      nt_we = req_q.link_valid;
      nt_wa = lnk_idx;
      nt_wd = {1'b0, hit_idx};
    end
    if (cmd.alloc_end) begin
      fm_we = 1'b1;
      fm_wa = hit_idx;
      fm_wd = 1'b1;
      nt_we = 1'b1;
      nt_wa = hit_idx;
    end
    if (cmd.free_wr) begin
      fm_we = 1'b1;
      nt_we = hit_found;
      nt_wa = hit_idx;
      nt_wd = succ;
    end
  end

  assign nt_ra = cmd.scan_step ? ptr[IDX_W-1:0] : blk_idx;

  // Bitmap memory.
  always_ff @(posedge clk) begin
    if (fm_we) begin
      free_mem[fm_wa] <= fm_wd;
    end
    fm_rd <= free_mem[ptr[IDX_W-1:0]];
  end

  // Next-block table memory.
  always_ff @(posedge clk) begin
    if (nt_we) begin
      next_mem[nt_wa] <= nt_wd;
    end
    nt_rd <= next_mem[nt_ra];
  end

  // Result register and output word.
  always_ff @(posedge clk) begin
    if (cmd.res_ok || cmd.res_full || cmd.res_range) begin
      res_status <= cmd.res_range ? ST_RANGE : (cmd.res_full ? ST_FULL : ST_OK);
      res_block  <= '0;
      res_end    <= 1'b0;
    end else if (cmd.res_alloc) begin
      res_status <= ST_OK;
      res_block  <= BLOCK_W'(hit_idx);
      res_end    <= 1'b0;
    end else if (cmd.next_get) begin
      res_status <= ST_OK;
      res_block  <= nt_rd[IDX_W] ? '0 : BLOCK_W'(nt_rd[IDX_W-1:0]);
      res_end    <= nt_rd[IDX_W];
    end
    if (cmd.load_out) begin
      rsp_data.status       <= res_status;
      rsp_data.result_block <= res_block;
      rsp_data.result_end   <= res_end;
    end
  end

endmodule

[sv/bca_ctrl.sv]
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the clear pass, the decode, the table scans and the response
// of each request word.
// ----------------------------------------------------------------------------
module bca_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bca_pkg::cmd_t cmd,
  input  bca_pkg::sts_t sts
);
  import bca_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.mode)
          OP_ALLOC: state_next = sts.lnk_oor ? S_RESP : S_ALLOC_SCAN;
          OP_FREE: begin
            if (sts.blk_oor) begin
              state_next = S_RESP;
            end else begin
              state_next = sts.flag ? S_FREE_GET : S_FREE_WR;
            end
          end
          OP_NEXT: state_next = sts.blk_oor ? S_RESP : S_NEXT_GET;
          default: state_next = S_RESP;
        endcase
      end
      S_ALLOC_SCAN: begin
        if (sts.scan_hit) begin
          state_next = S_ALLOC_LINK;
        end else if (sts.scan_exh) begin
          state_next = S_RESP;
        end
      end
      S_ALLOC_LINK: state_next = S_ALLOC_END;
      S_ALLOC_END:  state_next = S_RESP;
      S_FREE_GET:   state_next = S_FREE_SCAN;
      S_FREE_SCAN: begin
        if (sts.scan_hit || sts.scan_exh) state_next = S_FREE_WR;
      end
      S_FREE_WR:  state_next = S_RESP;
      S_NEXT_GET: state_next = S_RESP;
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd         = '0;
    cmd.load_in = in_valid && in_ready;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_DECODE: begin
        cmd.scan_start = 1'b1;
        case (sts.mode)
          OP_ALLOC: cmd.res_range = sts.lnk_oor;
          OP_FREE:  cmd.res_range = sts.blk_oor;
          OP_NEXT:  cmd.res_range = sts.blk_oor;
          OP_MARK: begin
            cmd.res_range = sts.blk_oor;
            cmd.wr_mark   = !sts.blk_oor;
            cmd.res_ok    = !sts.blk_oor;
          end
          OP_LINK: begin
            cmd.res_range = sts.blk_oor || sts.lnk_oor;
            cmd.wr_link   = !(sts.blk_oor || sts.lnk_oor);
            cmd.res_ok    = !(sts.blk_oor || sts.lnk_oor);
          end
          default: cmd.res_ok = 1'b1;
        endcase
      end
      S_ALLOC_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.res_full  = sts.scan_exh;
      end
      S_ALLOC_LINK: cmd.alloc_link = 1'b1;
      S_ALLOC_END: begin
        cmd.alloc_end = 1'b1;
        cmd.res_alloc = 1'b1;
      end
      S_FREE_GET: begin
        cmd.free_get   = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_FREE_SCAN: cmd.scan_step = 1'b1;
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        cmd.res_ok  = 1'b1;
      end
      S_NEXT_GET: cmd.next_get = 1'b1;
      S_RESP:     cmd.load_out = out_free;
      default: ;
    endcase
  end

endmodule
